// File: hdl/five_bit_text_codec_defines.svh
// assertion macros for the five-bit text codec
`ifndef FIVE_BIT_TEXT_CODEC_DEFINES_SVH
`define FIVE_BIT_TEXT_CODEC_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define FBTC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define FBTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBTC_ASSERT_IMPLIES(lbl, ante, cons)
`define FBTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/fbtc_pkg.sv
// types, constants and helpers shared by the five-bit text codec
package fbtc_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    CFG_MODE        = 1'b0,
    CFG_LINE_LENGTH = 1'b1
  } cfg_reg_e;

  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [7:0] NEWLINE_CODE    = 8'd10;
  localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'd90;
  localparam logic [7:0] CHAR_DIGIT_0    = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_5    = 8'd53;
  localparam logic [7:0] DIGIT_OFFSET    = 8'd22;
  localparam logic [7:0] LETTER_COUNT    = 8'd26;
  localparam logic [7:0] LINE_LEN_RESET  = 8'd72;
  localparam logic [7:0] LINE_LEN_MIN    = 8'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // up to three results of one input transaction
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] data;
  } bundle_t;

  // 5-bit group to character
  function automatic logic [7:0] char_of(logic [4:0] g);
    logic [7:0] g8;
    g8 = {3'b000, g};
    return (g8 < LETTER_COUNT) ? (g8 + CHAR_UPPER_A) : (g8 + DIGIT_OFFSET);
  endfunction

endpackage

// File: hdl/fbtc_core.sv
// input register, config and stream state, and the per-transaction step logic
module fbtc_core import fbtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output logic       bnd_valid_o,
  input  logic       bnd_ready_i,
  output bundle_t    bnd_o
);

  mode_e      mode_q;
  logic [7:0] line_len_q;
  logic       a_valid_q;
  in_item_t   a_item_q;
  logic [7:0] held_bits_q, held_bits_d;
  logic [2:0] held_cnt_q, held_cnt_d;
  logic [7:0] line_cnt_q, line_cnt_d;
  bundle_t    bnd;
  logic       advance;
  logic       accept;

  // step logic
  logic [7:0]  eff_len;
  logic [2:0]  n;
  logic [7:0]  hb_m;
  logic [12:0] enc_acc;
  logic [4:0]  g1, g2;
  logic        has1, has2, tail_nl;
  logic [2:0]  enc_newc;
  logic [12:0] enc_mask;
  logic [12:0] flush_sh;
  logic        dec_ok;
  logic [7:0]  dec_v8;
  logic [11:0] dec_acc;
  logic [11:0] dec_mask;
  logic [2:0]  dec_newc;
  logic [1:0]  cnt;
  logic [7:0]  lc;

  always_comb begin
    eff_len  = (line_len_q < LINE_LEN_MIN) ? LINE_LEN_MIN : line_len_q;
    n        = (held_cnt_q > 3'd4) ? 3'd4 : held_cnt_q;
    hb_m     = held_bits_q & ((8'd1 << n) - 8'd1);
    enc_acc  = {hb_m[4:0], a_item_q.in_byte};
    g1       = 5'(enc_acc >> ({1'b0, n} + 4'd3));
    g2       = 5'(enc_acc >> (n - 3'd2));
    enc_newc = (n >= 3'd2) ? (n - 3'd2) : (n + 3'd3);
    enc_mask = (13'd1 << enc_newc) - 13'd1;
    flush_sh = {5'b00000, held_bits_q} << (3'd5 - n);

    // decode character lookup
    dec_ok = 1'b0;
    dec_v8 = '0;
    if (a_item_q.in_byte >= CHAR_UPPER_A && a_item_q.in_byte <= CHAR_UPPER_Z) begin
      dec_ok = 1'b1;
      dec_v8 = a_item_q.in_byte - CHAR_UPPER_A;
    end else if (a_item_q.in_byte >= CHAR_DIGIT_0 && a_item_q.in_byte <= CHAR_DIGIT_5) begin
      dec_ok = 1'b1;
      dec_v8 = a_item_q.in_byte - DIGIT_OFFSET;
    end
    // at most seven held bits, so the top bit of the masked value is always zero
    dec_acc  = {7'(held_bits_q & ((8'd1 << held_cnt_q) - 8'd1)), dec_v8[4:0]};
    dec_newc = (held_cnt_q >= 3'd3) ? (held_cnt_q - 3'd3) : (held_cnt_q + 3'd5);
    dec_mask = (12'd1 << dec_newc) - 12'd1;

    has1        = 1'b0;
    has2        = 1'b0;
    tail_nl     = 1'b0;
    bnd         = '0;
    cnt         = 2'd0;
    lc          = line_cnt_q;
    held_bits_d = held_bits_q;
    held_cnt_d  = held_cnt_q;

    if (mode_q == MODE_ENCODE) begin
      if (a_item_q.func == FUNC_DATA) begin
        has1        = 1'b1;
        has2        = (n >= 3'd2);
        held_cnt_d  = enc_newc;
        held_bits_d = 8'(enc_acc & enc_mask);
      end else begin
        has1        = (n != 3'd0);
        g1          = flush_sh[4:0];
        tail_nl     = 1'b1;
        held_cnt_d  = '0;
        held_bits_d = '0;
      end
    end else begin
      if (a_item_q.func == FUNC_DATA) begin
        if (dec_ok) begin
          if (held_cnt_q >= 3'd3) begin
            bnd.data[0] = 8'(dec_acc >> (held_cnt_q - 3'd3));
            cnt         = 2'd1;
          end
          held_cnt_d  = dec_newc;
          held_bits_d = 8'(dec_acc & dec_mask);
        end
      end else begin
        held_cnt_d  = '0;
        held_bits_d = '0;
        lc          = '0;
      end
    end

    // first character, with line break
    if (has1) begin
      bnd.data[cnt] = char_of(g1);
      cnt           = cnt + 2'd1;
      lc            = lc + 8'd1;
      if (lc >= eff_len) begin
        bnd.data[cnt] = NEWLINE_CODE;
        cnt           = cnt + 2'd1;
        lc            = '0;
      end
    end
    // second character, with line break
    if (has2) begin
      bnd.data[cnt] = char_of(g2);
      cnt           = cnt + 2'd1;
      lc            = lc + 8'd1;
      if (lc >= eff_len) begin
        bnd.data[cnt] = NEWLINE_CODE;
        cnt           = cnt + 2'd1;
        lc            = '0;
      end
    end
    // close a non-empty line at end of stream
    if (tail_nl) begin
      if (lc != 8'd0) begin
        bnd.data[cnt] = NEWLINE_CODE;
        cnt           = cnt + 2'd1;
      end
      lc = '0;
    end

    bnd.count  = cnt;
    line_cnt_d = lc;
  end

  // handshake between input register and emitter
  assign advance     = a_valid_q && ((bnd.count == 2'd0) || bnd_ready_i);
  assign in_stall_o  = a_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign bnd_valid_o = a_valid_q;
  assign bnd_o       = bnd;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (advance) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= in_item_i;
    end
  end

  // config registers and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCODE;
      line_len_q  <= LINE_LEN_RESET;
      held_bits_q <= '0;
      held_cnt_q  <= '0;
      line_cnt_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_reg_e'(cfg_idx_i) == CFG_MODE) begin
        mode_q      <= mode_e'(cfg_data_i[0]);
        held_bits_q <= '0;
        held_cnt_q  <= '0;
        line_cnt_q  <= '0;
      end else begin
        line_len_q <= cfg_data_i;
      end
    end else if (advance) begin
      held_bits_q <= held_bits_d;
      held_cnt_q  <= held_cnt_d;
      line_cnt_q  <= line_cnt_d;
    end
  end

endmodule

// File: hdl/fbtc_emit.sv
// result register that hands out up to three results, one per cycle while the output is not stalled
module fbtc_emit import fbtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      bnd_valid_i,
  input  bundle_t   bnd_i,
  output logic      bnd_ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [2:0][7:0] data_q;
  logic [1:0]      cnt_q;
  logic [1:0]      idx_q;
  logic            is_last;
  logic            take;
  logic            load;

  assign out_valid_o = (cnt_q != 2'd0);
  assign is_last     = (idx_q == (cnt_q - 2'd1));
  assign take        = out_valid_o && !out_stall_i;
  assign bnd_ready_o = !out_valid_o || (take && is_last);
  assign load        = bnd_valid_i && bnd_ready_o && (bnd_i.count != 2'd0);

  assign out_item_o.out_byte = data_q[idx_q];
  assign out_item_o.last     = is_last;

  // result count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      cnt_q <= bnd_i.count;
      idx_q <= '0;
    end else if (take) begin
      if (is_last) begin
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // result data
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= bnd_i.data;
    end
  end

endmodule

// File: hdl/five_bit_text_codec.sv
// five-bit text codec top level: byte stream to A-Z/0-5 text lines and back
// path: a transaction passes the input register, then the result register, before its first result is valid
// throughput: one input transaction per cycle while the output is not stalled, when it gives at most one result;
//   an encoded byte gives one to three results (two characters and a newline at most)
// the result register hands out one result per cycle while the output is not stalled
// reset: asynchronous, clears config to encode mode with 72-character lines, empties state
`include "five_bit_text_codec_defines.svh"

module five_bit_text_codec import fbtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  logic    bnd_valid;
  logic    bnd_ready;
  bundle_t bnd;

  // step logic and stream state
  fbtc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .bnd_valid_o (bnd_valid),
    .bnd_ready_i (bnd_ready),
    .bnd_o       (bnd)
  );

  // result serializer
  fbtc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_valid_i (bnd_valid),
    .bnd_i       (bnd),
    .bnd_ready_o (bnd_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // a loaded result group shows up on the output next cycle
  `FBTC_ASSERT_NEXT(a_load_shows, bnd_valid && bnd_ready && (bnd.count != 2'd0), out_valid_o)
  // results of a transaction keep coming until the last one is taken
  `FBTC_ASSERT_NEXT(a_more_pending, out_valid_o && !out_stall_i && !out_item_o.last, out_valid_o)
  // input stalls only while the input register holds a transaction
  `FBTC_ASSERT_IMPLIES(a_stall_held, in_stall_o, bnd_valid)

endmodule

// File: test/testbench.sv
// self-checking testbench for the five-bit text codec: directed rows, then random streams
module testbench;
  import fbtc_pkg::*;

  localparam int MAX_SHOWN     = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int RANDOM_ITEMS  = 85;
  localparam int LIMIT_TIME    = 8_000_000;

  // one row of the directed table; typed_n < 0 leaves the check to the predictor
  typedef struct packed {
    logic       is_cfg;
    cfg_reg_e   reg_sel;
    logic       func;
    logic [7:0] value;
    int         typed_n;
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
  } dir_row_t;

  localparam int DIR_ROWS = 31;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // cfg   register         func        value         n   first   second        third
    // encode, reset line length
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h00,         1, 8'd65,  8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'hFF,         2, 8'd68,  8'd53,        8'd0},
    '{1'b0, CFG_MODE,        FUNC_FLUSH, 8'h00,         2, 8'd81,  NEWLINE_CODE, 8'd0},
    // flush with nothing pending
    '{1'b0, CFG_MODE,        FUNC_FLUSH, 8'hFF,         0, 8'd0,   8'd0,         8'd0},
    // line length of one acts as two
    '{1'b1, CFG_LINE_LENGTH, FUNC_DATA,  8'd1,          0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h00,         1, 8'd65,  8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'hFF,         3, 8'd68,  NEWLINE_CODE, 8'd53},
    '{1'b0, CFG_MODE,        FUNC_FLUSH, 8'h00,         2, 8'd81,  NEWLINE_CODE, 8'd0},
    // line length of zero
    '{1'b1, CFG_LINE_LENGTH, FUNC_DATA,  8'd0,          0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'hA5,        -1, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h5A,        -1, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_FLUSH, 8'h00,        -1, 8'd0,   8'd0,         8'd0},
    // longest lines, then lowered mid-line
    '{1'b1, CFG_LINE_LENGTH, FUNC_DATA,  8'd255,        0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h12,        -1, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h34,        -1, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h56,        -1, 8'd0,   8'd0,         8'd0},
    '{1'b1, CFG_LINE_LENGTH, FUNC_DATA,  8'd3,          0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'h78,        -1, 8'd0,   8'd0,         8'd0},
    // mode write mid-stream drops the pending bits and the open line
    '{1'b1, CFG_MODE,        FUNC_DATA,  8'd0,          0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_FLUSH, 8'h00,         0, 8'd0,   8'd0,         8'd0},
    // decode: range edges, characters just outside them, flush drops leftovers
    '{1'b1, CFG_MODE,        FUNC_DATA,  8'd1,          0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  CHAR_UPPER_A,  0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  CHAR_DIGIT_5,  1, 8'd7,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'd64,         0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'd91,         0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'd47,         0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'd54,         0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  8'hFF,         0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  CHAR_UPPER_Z,  0, 8'd0,   8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_DATA,  CHAR_DIGIT_0,  1, 8'd243, 8'd0,         8'd0},
    '{1'b0, CFG_MODE,        FUNC_FLUSH, 8'hFF,         0, 8'd0,   8'd0,         8'd0}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  cfg_reg_e   cfg_idx   = CFG_MODE;
  logic [7:0] cfg_data  = 8'd0;

  // predictor copy of registers and stream state
  mode_e      mode_reg     = MODE_ENCODE;
  logic [7:0] line_len_reg = LINE_LEN_RESET;
  logic [7:0] pend_bits    = '0;
  logic [2:0] pend_n       = '0;
  logic [7:0] col_count    = '0;

  out_item_t  step_bytes [$];
  out_item_t  owed_bytes [$];
  int         bad_count     = 0;
  bit         send_idle     = 1'b0;
  bit         recv_idle     = 1'b0;
  bit         long_hold_req = 1'b0;

  five_bit_text_codec uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor helpers
  function automatic void clear_stream_state();
    pend_bits = '0;
    pend_n    = '0;
    col_count = '0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    step_bytes.push_back('{out_byte: b, last: 1'b0});
  endfunction

  // one character, plus a newline once the line is full
  function automatic void put_char(input logic [4:0] g);
    logic [7:0] limit;
    put_byte((8'(g) < LETTER_COUNT) ? 8'(g) + CHAR_UPPER_A : 8'(g) + DIGIT_OFFSET);
    col_count = col_count + 8'd1;
    limit = (line_len_reg < LINE_LEN_MIN) ? LINE_LEN_MIN : line_len_reg;
    if (col_count >= limit) begin
      put_byte(NEWLINE_CODE);
      col_count = '0;
    end
  endfunction

  // expected results of one transaction, state advanced
  function automatic void translate_item(input in_item_t it);
    logic [15:0] acc;
    logic [7:0]  v;
    bit          ok;
    int          n;
    step_bytes.delete();
    if (mode_reg == MODE_ENCODE) begin
      n = (pend_n > 3'd4) ? 4 : int'(pend_n);
      if (it.func == FUNC_DATA) begin
        acc = ((16'(pend_bits) & ((16'd1 << n) - 16'd1)) << 8) | 16'(it.in_byte);
        n += 8;
        while (n >= 5) begin
          n -= 5;
          put_char(5'(acc >> n));
        end
        pend_n    = 3'(n);
        pend_bits = 8'(acc & ((16'd1 << n) - 16'd1));
      end else begin
        if (n != 0) put_char(5'(pend_bits << (5 - n)));
        if (col_count != 0) put_byte(NEWLINE_CODE);
        clear_stream_state();
      end
    end else if (it.func == FUNC_DATA) begin
      ok = 1'b1;
      v  = '0;
      if (it.in_byte >= CHAR_UPPER_A && it.in_byte <= CHAR_UPPER_Z) begin
        v = it.in_byte - CHAR_UPPER_A;
      end else if (it.in_byte >= CHAR_DIGIT_0 && it.in_byte <= CHAR_DIGIT_5) begin
        v = it.in_byte - DIGIT_OFFSET;
      end else begin
        ok = 1'b0;
      end
      if (ok) begin
        n   = int'(pend_n);
        acc = ((16'(pend_bits) & ((16'd1 << n) - 16'd1)) << 5) | 16'(v[4:0]);
        n += 5;
        if (n >= 8) begin
          n -= 8;
          put_byte(8'(acc >> n));
        end
        pend_n    = 3'(n);
        pend_bits = 8'(acc & ((16'd1 << n) - 16'd1));
      end
    end else begin
      clear_stream_state();
    end
    if (step_bytes.size() != 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
  endfunction

  // offer one transaction, record its expected results once accepted
  task automatic send_item(input in_item_t it, input int typed_n, input logic [2:0][7:0] typed);
    int gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    translate_item(it);
    if (typed_n >= 0) begin
      step_bytes.delete();
      for (int k = 0; k < typed_n; k++)
        step_bytes.push_back('{out_byte: typed[k], last: (k == typed_n - 1)});
    end
    foreach (step_bytes[k]) owed_bytes.push_back(step_bytes[k]);
  endtask

  // stop sending and let the block drain
  task automatic quiesce();
    in_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write on an idle block
  task automatic set_register(input cfg_reg_e sel, input logic [7:0] val);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == CFG_MODE) begin
      mode_reg = mode_e'(val[0]);
      clear_stream_state();
    end else begin
      line_len_reg = val;
    end
  endtask

  // result side: random stalls between results, one long hold on request
  initial begin : result_sink
    int wait_n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (out_valid && !out_stall) begin
        wait_n = recv_idle ? $urandom_range(0, 11) : 0;
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_bytes.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("unexpected result: byte %0d last %0b", out_item.out_byte, out_item.last);
      end else begin
        want = owed_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.last !== want.last) begin
          bad_count++;
          if (bad_count <= MAX_SHOWN)
            $display("result mismatch: expected byte %0d last %0b, got byte %0d last %0b",
                     want.out_byte, want.last, out_item.out_byte, out_item.last);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    in_item_t   it;
    dir_row_t   r;
    logic [7:0] len;
    logic [4:0] g;
    int         counted;
    int         phase;
    int         n_items;
    int         pick;
    bit         noise;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = DIRECTED[i];
      if (r.is_cfg) begin
        set_register(r.reg_sel, r.value);
      end else begin
        it.func    = r.func;
        it.in_byte = r.value;
        send_item(it, r.typed_n, {r.t2, r.t1, r.t0});
      end
    end

    // random streams, a fresh setting per phase
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       len = 8'd0;
        1:       len = 8'd1;
        2:       len = 8'd2;
        3:       len = 8'd255;
        default: len = 8'($urandom_range(3, 80));
      endcase
      set_register(CFG_LINE_LENGTH, len);
      set_register(CFG_MODE, {7'($urandom_range(0, 127)),
                              (phase == 2) ? 1'b0 : 1'($urandom_range(0, 1))});
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
      n_items   = $urandom_range(8, 20);
      // block fills up behind a long receiver hold
      if (phase == 2) begin
        send_idle     = 1'b0;
        n_items       = 20;
        long_hold_req = 1'b1;
      end
      for (int k = 0; k < n_items; k++) begin
        noise = 1'b0;
        pick  = $urandom_range(0, 99);
        if (pick < 8) begin
          it.func    = FUNC_FLUSH;
          it.in_byte = 8'($urandom_range(0, 255));
        end else if (mode_reg == MODE_ENCODE || pick < 85) begin
          it.func = FUNC_DATA;
          if (mode_reg == MODE_ENCODE) begin
            it.in_byte = 8'($urandom_range(0, 255));
          end else begin
            g = 5'($urandom_range(0, 31));
            it.in_byte = (8'(g) < LETTER_COUNT) ? 8'(g) + CHAR_UPPER_A : 8'(g) + DIGIT_OFFSET;
          end
        end else begin
          it.func    = FUNC_DATA;
          it.in_byte = 8'($urandom_range(0, 255));
          noise      = 1'b1;
        end
        send_item(it, -1, '0);
        if (!noise) counted++;
        // occasional pause until everything owed has come back
        if ($urandom_range(0, 29) == 0) quiesce();
      end
      if ($urandom_range(0, 1) != 0) begin
        it.func    = FUNC_FLUSH;
        it.in_byte = 8'($urandom_range(0, 255));
        send_item(it, -1, '0);
      end
      phase++;
    end

    quiesce();
    if (bad_count == 0 && owed_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/fbtc_pkg.sv
hdl/fbtc_core.sv
hdl/fbtc_emit.sv
hdl/five_bit_text_codec.sv
test/testbench.sv
